// ===== src/assert_macros.svh =====
// Assertion helpers, included by mfqs_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, switched off while rst_n is low
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication check: antecedent in one cycle, consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mfqs_pkg.sv =====
package mfqs_pkg;

    // Fixed field widths
    localparam int ID_W     = 8;
    localparam int TIME_W   = 16;
    localparam int CLK_W    = 32;
    localparam int STATUS_W = 3;
    localparam int LVL_W    = 2;

    // Number of priority levels, one quantum register each
    localparam int LEVELS    = 3;
    localparam int CFG_IDX_W = 2;

    // Default ring depth per level, also the total store limit
    localparam int QUEUE_DEPTH_DEF = 16;

    typedef enum logic [0:0] {
        CMD_ADD   = 1'b0,
        CMD_SLICE = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ACCEPTED = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_FINISHED = 3'd2,
        STAT_DEMOTED  = 3'd3,
        STAT_REQUEUED = 3'd4,
        STAT_IDLE     = 3'd5
    } status_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic [0:0]        cmd;
        logic [ID_W-1:0]   proc_id;
        logic [TIME_W-1:0] burst_time;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     served_id;
        logic [LVL_W-1:0]    served_level;
        logic [TIME_W-1:0]   time_left;
        logic [CLK_W-1:0]    finish_time;
    } out_item_t;

    // One stored process
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] remain;
    } entry_t;

    // Reset quantum of a level: 4, 8, 16, ...
    function automatic logic [TIME_W-1:0] quantum_reset(input int lvl);
        logic [31:0] q;
        q = 32'd4 << lvl;
        return q[TIME_W-1:0];
    endfunction

endpackage

// ===== src/mfqs_store.sv =====
module mfqs_store
    import mfqs_pkg::*;
#(
    parameter int DEPTH = LEVELS * QUEUE_DEPTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds its data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/mfqs_ctrl.sv =====
module mfqs_ctrl
    import mfqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [TIME_W-1:0] quantum [LEVELS],
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_data,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  entry_t            rd_data,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output entry_t            wr_data
);

    `include "assert_macros.svh"

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + $clog2(LEVELS + 1);

    // Queue bookkeeping
    logic [PTR_W-1:0] head_reg  [LEVELS];
    logic [PTR_W-1:0] head_next [LEVELS];
    logic [PTR_W-1:0] tail_reg  [LEVELS];
    logic [PTR_W-1:0] tail_next [LEVELS];
    logic [CNT_W-1:0] count_reg  [LEVELS];
    logic [CNT_W-1:0] count_next [LEVELS];
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CLK_W-1:0] clock_reg, clock_next;
    state_t           state_reg, state_next;

    // Item held between accept and execute
    logic [0:0]        cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] burst_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic              hit_reg;

    // Output register
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg, out_data_next;

    logic              in_xfer;
    logic              done;
    logic [LVL_W-1:0]  sel_lvl;
    logic              sel_hit;
    logic [LVL_W-1:0]  dst_lvl;
    logic [TIME_W-1:0] q;
    logic [TIME_W-1:0] rem_left;
    logic              finish;
    logic [SUM_W-1:0]  count_sum;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] p1;
        p1 = {1'b0, p} + 1'b1;
        return (p1 >= (PTR_W + 1)'(QUEUE_DEPTH)) ? '0 : p1[PTR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                    input logic [PTR_W-1:0] p);
        return ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign done     = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);

    // Highest-priority non-empty level
    always_comb
    begin
        sel_lvl = '0;
        sel_hit = 1'b0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                sel_lvl = LVL_W'(i);
                sel_hit = 1'b1;
            end
        end
    end

    // Head read issued on the accepting edge
    assign rd_en   = in_xfer && (in_data.cmd == CMD_SLICE) && sel_hit;
    assign rd_addr = slot_addr(sel_lvl, head_reg[sel_lvl]);

    // Slice arithmetic on the entry read back
    assign q        = quantum[lvl_reg];
    assign finish   = (rd_data.remain <= q);
    assign rem_left = rd_data.remain - q;
    assign dst_lvl  = (lvl_reg == LVL_W'(LEVELS - 1)) ? lvl_reg : lvl_reg + 1'b1;

    // Execute step: update queues, write back, form the result
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        clock_next     = clock_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = slot_addr('0, tail_reg[0]);
        wr_data        = '{id: id_reg, remain: burst_reg};

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (done)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_data_next.served_id    = id_reg;
                    out_data_next.served_level = '0;
                    out_data_next.time_left    = burst_reg;
                    out_data_next.finish_time  = clock_reg;
                    if (cmd_reg == CMD_ADD)
                    begin
                        if (total_reg >= CNT_W'(QUEUE_DEPTH))
                        begin
                            out_data_next.status = STAT_FULL;
                        end
                        else
                        begin
                            out_data_next.status = STAT_ACCEPTED;
                            wr_en         = 1'b1;
                            tail_next[0]  = ring_next(tail_reg[0]);
                            count_next[0] = count_reg[0] + 1'b1;
                            total_next    = total_reg + 1'b1;
                        end
                    end
                    else if (!hit_reg)
                    begin
                        out_data_next.status    = STAT_IDLE;
                        out_data_next.served_id = '0;
                        out_data_next.time_left = '0;
                    end
                    else
                    begin
                        clock_next          = clock_reg + CLK_W'(q);
                        head_next[lvl_reg]  = ring_next(head_reg[lvl_reg]);
                        count_next[lvl_reg] = count_next[lvl_reg] - 1'b1;
                        out_data_next.served_id    = rd_data.id;
                        out_data_next.served_level = lvl_reg;
                        out_data_next.finish_time  = clock_next;
                        if (finish)
                        begin
                            out_data_next.status    = STAT_FINISHED;
                            out_data_next.time_left = '0;
                            total_next              = total_reg - 1'b1;
                        end
                        else
                        begin
                            out_data_next.status    = (dst_lvl == lvl_reg) ?
                                                      STAT_REQUEUED : STAT_DEMOTED;
                            out_data_next.time_left = rem_left;
                            wr_en               = 1'b1;
                            wr_addr             = slot_addr(dst_lvl, tail_reg[dst_lvl]);
                            wr_data             = '{id: rd_data.id, remain: rem_left};
                            tail_next[dst_lvl]  = ring_next(tail_reg[dst_lvl]);
                            count_next[dst_lvl] = count_next[dst_lvl] + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            total_reg     <= '0;
            clock_reg     <= '0;
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            clock_reg     <= clock_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item capture and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg   <= in_data.cmd;
            id_reg    <= in_data.proc_id;
            burst_reg <= in_data.burst_time;
            lvl_reg   <= sel_lvl;
            hit_reg   <= sel_hit;
        end
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Level occupancy total, for checking only
    always_comb
    begin
        count_sum = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            count_sum = count_sum + SUM_W'(count_reg[i]);
        end
    end

    `ASSERT_CLK(a_total_bound, total_reg <= CNT_W'(QUEUE_DEPTH),
        "process count above store size")
    `ASSERT_CLK(a_count_sum, count_sum == SUM_W'(total_reg),
        "level counts disagree with total count")
    `ASSERT_CLK(a_result_after_exec, $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC),
        "result raised without an execute step")
    `ASSERT_NEXT(a_accept_exec, in_xfer, state_reg == ST_EXEC,
        "accepted item did not enter execute")

endmodule

// ===== src/multilevel_feedback_queue_scheduler_top.sv =====
// Multilevel feedback queue scheduler: LEVELS FIFO levels share one entry store of
// LEVELS x QUEUE_DEPTH entries. An add item (cmd 0) queues a process at the tail of
// level 0 unless QUEUE_DEPTH processes are already held; a slice item (cmd 1) serves
// the head of the lowest-numbered non-empty level, charges that level's quantum and
// either finishes it, demotes it, or requeues it at the bottom (idle result if all
// empty). Every item gives exactly one result. Transfer issues any head entry
// read from the two-port synchronous store; execution takes the read data, writes
// the entry back to its new level and loads the output register. The output register
// lets the next item be transferred while a result still waits; an item finishing
// while the previous result is still held waits for it. Quanta are written through
// cfg_wen, cfg_index (0 to 2) and cfg_data, by the user only while the block is
// idle, not enforced by the block. The store needs no initialisation after reset.
module multilevel_feedback_queue_scheduler_top
    import mfqs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data
);

    localparam int MEM_DEPTH = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    logic [TIME_W-1:0] quantum_reg [LEVELS];
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;

    // Quantum registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                quantum_reg[i] <= quantum_reset(i);
            end
        end
        else
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                if (cfg_wen && (cfg_index == CFG_IDX_W'(i)))
                begin
                    quantum_reg[i] <= cfg_data;
                end
            end
        end
    end

    mfqs_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .quantum   (quantum_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    mfqs_store #(
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule
